@@ rtl/core/i2crm_pkg.sv @@
`timescale 1ns / 1ps
package i2crm_pkg;

  localparam int CountBits = 12;

  localparam logic [19:0] StretchTimeoutReset = 20'd120000;
  localparam logic [15:0] AckTimeoutReset     = 16'd250;
  localparam logic [4:0]  PulseLimitReset     = 5'd18;

  // operation codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_PROBE   = 3'd3;
  localparam logic [2:0] OP_RECOVER = 3'd4;
  localparam logic [2:0] OP_SUPPLY  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_STRETCH = 2'd0;
  localparam logic [1:0] REG_ACK     = 2'd1;
  localparam logic [1:0] REG_PULSE   = 2'd2;

  // transfer kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_PROBE   = 2'd2;
  localparam logic [1:0] KIND_RECOVER = 2'd3;

  // transfer stages
  localparam logic [2:0] STG_ADDR_W  = 3'd0;
  localparam logic [2:0] STG_REG     = 3'd1;
  localparam logic [2:0] STG_DATA    = 3'd2;
  localparam logic [2:0] STG_ADDR_R  = 3'd3;
  localparam logic [2:0] STG_REC     = 3'd4;
  localparam logic [2:0] STG_REC_PRB = 3'd5;

  // one queued input beat
  typedef struct packed {
    logic [2:0] operation;
    logic       scl_level;
    logic       sda_level;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [11:0] byte_count;
    logic [7:0] write_byte;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic       success;
    logic       done_res;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } res_t;

endpackage

@@ rtl/core/i2crm_front.sv @@
`timescale 1ns / 1ps
module i2crm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,
  output logic                q_valid,
  input  logic                q_ready,
  output i2crm_pkg::cmd_t     q_data
);

  // two-entry queue between unpack and engine
  i2crm_pkg::cmd_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  i2crm_pkg::cmd_t unpacked;

  // unpack the beat, fields from the lowest bit up
  always_comb begin
    unpacked.operation        = s_axis_tdata[2:0];
    unpacked.scl_level        = s_axis_tdata[3];
    unpacked.sda_level        = s_axis_tdata[4];
    unpacked.device_address   = s_axis_tdata[11:5];
    unpacked.register_address = s_axis_tdata[19:12];
    unpacked.byte_count       = s_axis_tdata[31:20];
    unpacked.write_byte       = s_axis_tdata[39:32];
  end

  assign s_axis_tready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mem[wr_ptr] <= unpacked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, s_axis_tvalid && s_axis_tready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

@@ rtl/core/i2crm_engine.sv @@
`timescale 1ns / 1ps
module i2crm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  i2crm_pkg::cmd_t q_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [19:0]     cfg_data,
  output logic            r_valid,
  input  logic            r_ready,
  output i2crm_pkg::res_t r_data
);

  typedef enum logic [30:0] {
    P_IDLE       = 31'd1 << 0,
    P_CHECK      = 31'd1 << 1,
    P_REC_TEST   = 31'd1 << 2,
    P_REC_LOW    = 31'd1 << 3,
    P_REC_WAIT   = 31'd1 << 4,
    P_REC_HIGH   = 31'd1 << 5,
    P_ST_WAIT    = 31'd1 << 6,
    P_ST_DELAY   = 31'd1 << 7,
    P_ST_SDA     = 31'd1 << 8,
    P_ST_SCL     = 31'd1 << 9,
    P_TX_SETUP   = 31'd1 << 10,
    P_TX_WAIT    = 31'd1 << 11,
    P_TX_HIGH    = 31'd1 << 12,
    P_TX_LOW     = 31'd1 << 13,
    P_ACK_SETUP  = 31'd1 << 14,
    P_ACK_WAIT   = 31'd1 << 15,
    P_ACK_HIGH   = 31'd1 << 16,
    P_ACK_LOW    = 31'd1 << 17,
    P_NEED       = 31'd1 << 18,
    P_RX_REL     = 31'd1 << 19,
    P_RX_WAIT    = 31'd1 << 20,
    P_RX_HIGH    = 31'd1 << 21,
    P_RX_ACKSET  = 31'd1 << 22,
    P_RX_ACKREL  = 31'd1 << 23,
    P_RX_ACKWAIT = 31'd1 << 24,
    P_RX_ACKHIGH = 31'd1 << 25,
    P_SP_BEGIN   = 31'd1 << 26,
    P_SP_LOW     = 31'd1 << 27,
    P_SP_WAIT    = 31'd1 << 28,
    P_SP_HIGH    = 31'd1 << 29,
    P_SP_END     = 31'd1 << 30
  } phase_t;

  localparam logic [i2crm_pkg::CountBits-1:0] CountOne =
    {{(i2crm_pkg::CountBits-1){1'b0}}, 1'b1};

  logic [19:0] stretch_timeout;
  logic [15:0] ack_timeout;
  logic [4:0]  pulse_limit;

  phase_t phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [i2crm_pkg::CountBits-1:0] bytes_left, bytes_left_next;
  logic [19:0] wait_counter, wait_counter_next;
  logic [4:0]  pulse_counter, pulse_counter_next;
  logic [6:0]  held_address, held_address_next;
  logic [7:0]  held_register, held_register_next;
  logic [1:0]  transfer_kind, transfer_kind_next;
  logic        transfer_ok, transfer_ok_next;
  logic        scl_drv, scl_drv_next, sda_drv, sda_drv_next;
  logic [2:0]  stage, stage_next;
  logic        o_valid, o_done, o_ok;
  logic [7:0]  o_data;

  logic fire;
  logic scl, sda, free_bus, scl_ok, scl_to;
  logic [7:0] load_val;
  logic       do_load;

  // output register slot frees as soon as it is taken
  assign q_ready = !r_valid || r_ready;
  assign fire = q_valid && q_ready;
  assign cfg_ready = 1'b1;

  assign scl = q_data.scl_level;
  assign sda = q_data.sda_level;
  assign free_bus = scl && sda;
  assign scl_ok = scl;
  assign scl_to = !scl && (wait_counter >= stretch_timeout);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_timeout <= i2crm_pkg::StretchTimeoutReset;
      ack_timeout     <= i2crm_pkg::AckTimeoutReset;
      pulse_limit     <= i2crm_pkg::PulseLimitReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2crm_pkg::REG_STRETCH: stretch_timeout <= cfg_data;
        i2crm_pkg::REG_ACK:     ack_timeout <= cfg_data[15:0];
        i2crm_pkg::REG_PULSE:   pulse_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // phase machine, one beat per cycle while beats are queued and the result register can take them
  always_comb begin
    phase_next = phase;
    bit_index_next = bit_index;
    shift_byte_next = shift_byte;
    bytes_left_next = bytes_left;
    wait_counter_next = wait_counter;
    pulse_counter_next = pulse_counter;
    held_address_next = held_address;
    held_register_next = held_register;
    transfer_kind_next = transfer_kind;
    transfer_ok_next = transfer_ok;
    scl_drv_next = scl_drv;
    sda_drv_next = sda_drv;
    stage_next = stage;
    o_valid = 1'b0;
    o_data = 8'd0;
    o_done = 1'b0;
    o_ok = 1'b0;
    load_val = 8'd0;
    do_load = 1'b0;

    if (q_data.operation == i2crm_pkg::OP_TICK) begin
      case (phase)
        P_CHECK: begin
          if (transfer_kind == i2crm_pkg::KIND_RECOVER) begin
            o_done = 1'b1; o_ok = free_bus; phase_next = P_IDLE;
            scl_drv_next = 1'b0; sda_drv_next = 1'b0;
          end else if (stage == i2crm_pkg::STG_REC_PRB || !(free_bus ||
                       stage == i2crm_pkg::STG_ADDR_W)) begin
            o_done = 1'b1; phase_next = P_IDLE;
            scl_drv_next = 1'b0; sda_drv_next = 1'b0;
          end else if (free_bus) begin
            scl_drv_next = 1'b0; sda_drv_next = 1'b0;
            stage_next = i2crm_pkg::STG_ADDR_W; phase_next = P_ST_WAIT;
          end else begin
            stage_next = i2crm_pkg::STG_REC; pulse_counter_next = 5'd0;
            phase_next = P_REC_TEST;
          end
          wait_counter_next = 20'd0;
        end
        P_REC_TEST: begin
          wait_counter_next = 20'd0;
          if (sda) phase_next = P_SP_BEGIN;
          else if (pulse_counter >= pulse_limit) phase_next = P_CHECK;
          else begin
            scl_drv_next = 1'b1;
            pulse_counter_next = pulse_counter + 5'd1;
            phase_next = P_REC_LOW;
          end
        end
        P_REC_LOW: begin
          scl_drv_next = 1'b0; phase_next = P_REC_WAIT; wait_counter_next = 20'd0;
        end
        P_REC_WAIT: begin
          if (scl_ok || scl_to) begin
            phase_next = P_REC_HIGH; wait_counter_next = 20'd0;
          end else wait_counter_next = wait_counter + 20'd1;
        end
        P_REC_HIGH: begin
          phase_next = P_REC_TEST; wait_counter_next = 20'd0;
        end
        P_ST_WAIT: begin
          if (scl_ok) begin
            phase_next = P_ST_DELAY; wait_counter_next = 20'd0;
          end else if (scl_to) begin
            transfer_ok_next = 1'b0;
            wait_counter_next = 20'd0;
            if (stage == i2crm_pkg::STG_ADDR_R) phase_next = P_SP_BEGIN;
            else if (transfer_kind == i2crm_pkg::KIND_PROBE) begin
              stage_next = i2crm_pkg::STG_REC_PRB; pulse_counter_next = 5'd0;
              phase_next = P_REC_TEST;
            end else begin
              o_done = 1'b1; phase_next = P_IDLE;
              scl_drv_next = 1'b0; sda_drv_next = 1'b0;
            end
          end else wait_counter_next = wait_counter + 20'd1;
        end
        P_ST_DELAY: begin
          sda_drv_next = 1'b1; phase_next = P_ST_SDA; wait_counter_next = 20'd0;
        end
        P_ST_SDA: begin
          scl_drv_next = 1'b1; phase_next = P_ST_SCL; wait_counter_next = 20'd0;
        end
        P_ST_SCL: begin
          do_load = 1'b1;
          load_val = {held_address, stage == i2crm_pkg::STG_ADDR_R};
        end
        P_TX_SETUP: begin
          scl_drv_next = 1'b0; phase_next = P_TX_WAIT; wait_counter_next = 20'd0;
        end
        P_TX_WAIT, P_ACK_WAIT, P_RX_WAIT, P_RX_ACKWAIT: begin
          if (scl_ok) begin
            wait_counter_next = 20'd0;
            case (phase)
              P_TX_WAIT:  phase_next = P_TX_HIGH;
              P_ACK_WAIT: phase_next = P_ACK_HIGH;
              P_RX_WAIT:  phase_next = P_RX_HIGH;
              default:    phase_next = P_RX_ACKHIGH;
            endcase
          end else if (scl_to) begin
            transfer_ok_next = 1'b0; phase_next = P_SP_BEGIN; wait_counter_next = 20'd0;
          end else wait_counter_next = wait_counter + 20'd1;
        end
        P_TX_HIGH: begin
          scl_drv_next = 1'b1;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next = bit_index + 4'd1;
          phase_next = P_TX_LOW; wait_counter_next = 20'd0;
        end
        P_TX_LOW: begin
          wait_counter_next = 20'd0;
          if (bit_index >= 4'd8) begin
            sda_drv_next = 1'b0; phase_next = P_ACK_SETUP;
          end else begin
            sda_drv_next = !shift_byte[7]; phase_next = P_TX_SETUP;
          end
        end
        P_ACK_SETUP: begin
          scl_drv_next = 1'b0; phase_next = P_ACK_WAIT; wait_counter_next = 20'd0;
        end
        P_ACK_HIGH: begin
          if (!sda) begin
            scl_drv_next = 1'b1; phase_next = P_ACK_LOW; wait_counter_next = 20'd0;
          end else if ({4'd0, wait_counter} >= {8'd0, ack_timeout}) begin
            scl_drv_next = 1'b1; transfer_ok_next = 1'b0;
            phase_next = P_SP_BEGIN; wait_counter_next = 20'd0;
          end else wait_counter_next = wait_counter + 20'd1;
        end
        P_ACK_LOW: begin
          wait_counter_next = 20'd0;
          if (stage == i2crm_pkg::STG_ADDR_W) begin
            stage_next = i2crm_pkg::STG_REG;
            do_load = 1'b1; load_val = held_register;
          end else if (stage == i2crm_pkg::STG_REG &&
                       transfer_kind == i2crm_pkg::KIND_READ) begin
            stage_next = i2crm_pkg::STG_ADDR_R;
            scl_drv_next = 1'b0; sda_drv_next = 1'b0; phase_next = P_ST_WAIT;
          end else if (stage == i2crm_pkg::STG_REG || stage == i2crm_pkg::STG_DATA) begin
            if (stage == i2crm_pkg::STG_DATA) begin
              bytes_left_next = bytes_left - CountOne;
            end
            if (bytes_left_next == '0) begin
              transfer_ok_next = 1'b1; phase_next = P_SP_BEGIN;
            end else phase_next = P_NEED;
          end else begin
            bit_index_next = 4'd0; shift_byte_next = 8'd0;
            sda_drv_next = 1'b0; phase_next = P_RX_REL;
          end
        end
        P_RX_REL, P_RX_ACKREL: begin
          scl_drv_next = 1'b0; wait_counter_next = 20'd0;
          phase_next = (phase == P_RX_REL) ? P_RX_WAIT : P_RX_ACKWAIT;
        end
        P_RX_HIGH: begin
          shift_byte_next = {shift_byte[6:0], sda};
          bit_index_next = bit_index + 4'd1;
          scl_drv_next = 1'b1; wait_counter_next = 20'd0;
          phase_next = (bit_index_next >= 4'd8) ? P_RX_ACKSET : P_RX_REL;
        end
        P_RX_ACKSET: begin
          // more than one byte left: ack this one
          sda_drv_next = (bytes_left[i2crm_pkg::CountBits-1:1] != '0);
          phase_next = P_RX_ACKREL;
          wait_counter_next = 20'd0;
        end
        P_RX_ACKHIGH: begin
          scl_drv_next = 1'b1; sda_drv_next = 1'b0;
          o_valid = 1'b1; o_data = shift_byte;
          bytes_left_next = bytes_left - CountOne;
          wait_counter_next = 20'd0;
          if (bytes_left_next == '0) begin
            transfer_ok_next = 1'b1; phase_next = P_SP_BEGIN;
          end else begin
            bit_index_next = 4'd0; shift_byte_next = 8'd0; phase_next = P_RX_REL;
          end
        end
        P_SP_BEGIN: begin
          sda_drv_next = 1'b1; phase_next = P_SP_LOW; wait_counter_next = 20'd0;
        end
        P_SP_LOW: begin
          scl_drv_next = 1'b0; phase_next = P_SP_WAIT; wait_counter_next = 20'd0;
        end
        P_SP_WAIT: begin
          if (scl_ok) begin
            phase_next = P_SP_HIGH; wait_counter_next = 20'd0;
          end else if (scl_to) begin
            sda_drv_next = 1'b0; phase_next = P_SP_END; wait_counter_next = 20'd0;
          end else wait_counter_next = wait_counter + 20'd1;
        end
        P_SP_HIGH: begin
          sda_drv_next = 1'b0; phase_next = P_SP_END; wait_counter_next = 20'd0;
        end
        P_SP_END: begin
          wait_counter_next = 20'd0;
          if (transfer_kind == i2crm_pkg::KIND_RECOVER || stage >= i2crm_pkg::STG_REC) begin
            phase_next = P_CHECK;
          end else if (transfer_kind == i2crm_pkg::KIND_PROBE && !transfer_ok) begin
            stage_next = i2crm_pkg::STG_REC_PRB; pulse_counter_next = 5'd0;
            phase_next = P_REC_TEST;
          end else begin
            o_done = 1'b1; o_ok = transfer_ok; phase_next = P_IDLE;
            scl_drv_next = 1'b0; sda_drv_next = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (phase == P_IDLE && (q_data.operation == i2crm_pkg::OP_WRITE ||
                 q_data.operation == i2crm_pkg::OP_READ ||
                 q_data.operation == i2crm_pkg::OP_PROBE)) begin
      held_address_next = q_data.device_address;
      held_register_next = q_data.register_address;
      bytes_left_next = (q_data.operation == i2crm_pkg::OP_PROBE) ? '0 :
                        q_data.byte_count[i2crm_pkg::CountBits-1:0];
      transfer_kind_next = q_data.operation[1:0] - 2'd1;
      stage_next = i2crm_pkg::STG_ADDR_W;
      transfer_ok_next = 1'b0; bit_index_next = 4'd0; shift_byte_next = 8'd0;
      wait_counter_next = 20'd0;
      if (q_data.operation == i2crm_pkg::OP_READ && bytes_left_next == '0) begin
        o_done = 1'b1; phase_next = P_IDLE;
        scl_drv_next = 1'b0; sda_drv_next = 1'b0;
      end else phase_next = P_CHECK;
    end else if (phase == P_IDLE && q_data.operation == i2crm_pkg::OP_RECOVER) begin
      transfer_kind_next = i2crm_pkg::KIND_RECOVER;
      transfer_ok_next = 1'b0;
      stage_next = i2crm_pkg::STG_REC; pulse_counter_next = 5'd0;
      phase_next = P_REC_TEST; wait_counter_next = 20'd0;
    end else if (phase == P_NEED && q_data.operation == i2crm_pkg::OP_SUPPLY) begin
      stage_next = i2crm_pkg::STG_DATA;
      do_load = 1'b1; load_val = q_data.write_byte;
    end

    // byte load shared by address, register and data
    if (do_load) begin
      shift_byte_next = load_val;
      bit_index_next = 4'd0;
      sda_drv_next = !load_val[7];
      phase_next = P_TX_SETUP;
      wait_counter_next = 20'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      bit_index <= 4'd0;
      shift_byte <= 8'd0;
      bytes_left <= '0;
      wait_counter <= 20'd0;
      pulse_counter <= 5'd0;
      held_address <= 7'd0;
      held_register <= 8'd0;
      transfer_kind <= 2'd0;
      transfer_ok <= 1'b0;
      scl_drv <= 1'b0;
      sda_drv <= 1'b0;
      stage <= 3'd0;
    end else if (fire) begin
      phase <= phase_next;
      bit_index <= bit_index_next;
      shift_byte <= shift_byte_next;
      bytes_left <= bytes_left_next;
      wait_counter <= wait_counter_next;
      pulse_counter <= pulse_counter_next;
      held_address <= held_address_next;
      held_register <= held_register_next;
      transfer_kind <= transfer_kind_next;
      transfer_ok <= transfer_ok_next;
      scl_drv <= scl_drv_next;
      sda_drv <= sda_drv_next;
      stage <= stage_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (fire) begin
      r_valid <= 1'b1;
    end else if (r_ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_data.scl_pull_low <= scl_drv_next;
      r_data.sda_pull_low <= sda_drv_next;
      r_data.read_data    <= o_data;
      r_data.read_valid   <= o_valid;
      r_data.need_byte    <= (phase_next == P_NEED);
      r_data.busy_res     <= (phase_next != P_IDLE);
      r_data.done_res     <= o_done;
      r_data.success      <= o_ok;
    end
  end

endmodule

@@ rtl/core/i2c_register_master_core.sv @@
`timescale 1ns / 1ps
// path: an accepted input beat is held in the input queue, and its result beat is then
// registered in the phase engine's result register
// throughput: one beat per cycle, set by the phase engine step, while m_axis_tready keeps up
// reset: synchronous rst returns the bus engine to idle with both lines released
// and loads the timeout and recovery registers with their default values
module i2c_register_master_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation, scl_level, sda_level, device_address, register_address,
  // byte_count, write_byte
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_pull_low, sda_pull_low, read_data, read_valid, need_byte, busy_res,
  // done_res, success
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic            q_valid, q_ready;
  i2crm_pkg::cmd_t q_data;
  i2crm_pkg::res_t r_data;

  i2crm_front u_front (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_valid, .q_ready, .q_data
  );

  i2crm_engine u_engine (
    .clk, .rst, .q_valid, .q_ready, .q_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data
  );

  // pack result fields from the lowest bit up, zero fill to two bytes
  assign m_axis_tdata = {1'b0, r_data.success, r_data.done_res, r_data.busy_res,
                         r_data.need_byte, r_data.read_valid, r_data.read_data,
                         r_data.sda_pull_low, r_data.scl_pull_low};

endmodule

@@ test/tb_i2c_register_master_core.sv @@
`timescale 1ns / 1ps
module tb_i2c_register_master_core;

  // bus engine phases
  typedef enum logic [4:0] {
    PH_IDLE, PH_CHECK, PH_REC_TEST, PH_REC_LOW, PH_REC_WAIT, PH_REC_HIGH,
    PH_ST_WAIT, PH_ST_DELAY, PH_ST_SDA, PH_ST_SCL, PH_TX_SETUP, PH_TX_WAIT,
    PH_TX_HIGH, PH_TX_LOW, PH_ACK_SETUP, PH_ACK_WAIT, PH_ACK_HIGH, PH_ACK_LOW,
    PH_NEED, PH_RX_REL, PH_RX_WAIT, PH_RX_HIGH, PH_RX_ACKSET, PH_RX_ACKREL,
    PH_RX_ACKWAIT, PH_RX_ACKHIGH, PH_SP_BEGIN, PH_SP_LOW, PH_SP_WAIT,
    PH_SP_HIGH, PH_SP_END
  } phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  i2c_register_master_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted bus engine state and registers
  phase_e      ph;
  logic [3:0]  bidx;
  logic [7:0]  shb;
  logic [11:0] left;
  logic [19:0] wcnt;
  logic [4:0]  pcnt;
  logic [6:0]  haddr;
  logic [7:0]  hreg;
  logic [1:0]  kind;
  logic        tok;
  logic [1:0]  drv;
  logic [2:0]  stg;
  logic [19:0] stretch_to;
  logic [15:0] ack_to;
  logic [4:0]  pulse_lim;
  logic        o_valid, o_done, o_ok;
  logic [7:0]  o_data;

  logic [39:0] cmd_q[$];
  logic [15:0] beat_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          reads_seen = 0;
  int          dones_seen = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          ack_miss_pct = 15;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          cycles = 0;

  function automatic void go(phase_e p);
    ph = p;
    wcnt = '0;
  endfunction

  function automatic int scl_wait(logic scl);
    if (scl) return 1;
    if (wcnt >= stretch_to) return -1;
    wcnt = wcnt + 20'd1;
    return 0;
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shb = b;
    bidx = '0;
    drv[1] = ~b[7];
    go(PH_TX_SETUP);
  endfunction

  function automatic void finish_xfer(logic ok);
    o_done = 1'b1;
    o_ok = ok;
    drv = '0;
    go(PH_IDLE);
  endfunction

  function automatic void begin_recovery(logic [2:0] s);
    stg = s;
    pcnt = '0;
    go(PH_REC_TEST);
  endfunction

  function automatic void end_xfer();
    if (kind == i2crm_pkg::KIND_PROBE && !tok) begin_recovery(i2crm_pkg::STG_REC_PRB);
    else finish_xfer(tok);
  endfunction

  function automatic void fail_stop();
    tok = 1'b0;
    go(PH_SP_BEGIN);
  endfunction

  function automatic void data_or_stop();
    if (left == 12'd0) begin
      tok = 1'b1;
      go(PH_SP_BEGIN);
    end else go(PH_NEED);
  endfunction

  // one delay slot of the bus engine
  function automatic void bus_tick(logic scl, logic sda);
    int r;
    case (ph)
      PH_CHECK: begin
        if (kind == i2crm_pkg::KIND_RECOVER) finish_xfer(scl & sda);
        else if (stg == i2crm_pkg::STG_REC_PRB) finish_xfer(1'b0);
        else if (scl & sda) begin
          drv = '0;
          stg = i2crm_pkg::STG_ADDR_W;
          go(PH_ST_WAIT);
        end else if (stg == i2crm_pkg::STG_ADDR_W) begin_recovery(i2crm_pkg::STG_REC);
        else finish_xfer(1'b0);
      end
      PH_REC_TEST: begin
        if (sda) go(PH_SP_BEGIN);
        else if (pcnt >= pulse_lim) go(PH_CHECK);
        else begin
          drv[0] = 1'b1;
          pcnt = pcnt + 5'd1;
          go(PH_REC_LOW);
        end
      end
      PH_REC_LOW: begin
        drv[0] = 1'b0;
        go(PH_REC_WAIT);
      end
      PH_REC_WAIT: if (scl_wait(scl) != 0) go(PH_REC_HIGH);
      PH_REC_HIGH: go(PH_REC_TEST);
      PH_ST_WAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_ST_DELAY);
        else if (r < 0) begin
          if (stg == i2crm_pkg::STG_ADDR_R) fail_stop();
          else begin
            tok = 1'b0;
            end_xfer();
          end
        end
      end
      PH_ST_DELAY: begin
        drv[1] = 1'b1;
        go(PH_ST_SDA);
      end
      PH_ST_SDA: begin
        drv[0] = 1'b1;
        go(PH_ST_SCL);
      end
      PH_ST_SCL: load_byte({haddr, stg == i2crm_pkg::STG_ADDR_R});
      PH_TX_SETUP: begin
        drv[0] = 1'b0;
        go(PH_TX_WAIT);
      end
      PH_TX_WAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_TX_HIGH);
        else if (r < 0) fail_stop();
      end
      PH_TX_HIGH: begin
        drv[0] = 1'b1;
        shb = {shb[6:0], 1'b0};
        bidx = bidx + 4'd1;
        go(PH_TX_LOW);
      end
      PH_TX_LOW: begin
        if (bidx >= 4'd8) begin
          drv[1] = 1'b0;
          go(PH_ACK_SETUP);
        end else begin
          drv[1] = ~shb[7];
          go(PH_TX_SETUP);
        end
      end
      PH_ACK_SETUP: begin
        drv[0] = 1'b0;
        go(PH_ACK_WAIT);
      end
      PH_ACK_WAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_ACK_HIGH);
        else if (r < 0) fail_stop();
      end
      PH_ACK_HIGH: begin
        if (!sda) begin
          drv[0] = 1'b1;
          go(PH_ACK_LOW);
        end else if (wcnt >= {4'd0, ack_to}) begin
          drv[0] = 1'b1;
          fail_stop();
        end else wcnt = wcnt + 20'd1;
      end
      PH_ACK_LOW: begin
        if (stg == i2crm_pkg::STG_ADDR_W) begin
          stg = i2crm_pkg::STG_REG;
          load_byte(hreg);
        end else if (stg == i2crm_pkg::STG_REG) begin
          if (kind == i2crm_pkg::KIND_READ) begin
            stg = i2crm_pkg::STG_ADDR_R;
            drv = '0;
            go(PH_ST_WAIT);
          end else data_or_stop();
        end else if (stg == i2crm_pkg::STG_DATA) begin
          left = left - 12'd1;
          data_or_stop();
        end else begin
          bidx = '0;
          shb = '0;
          drv[1] = 1'b0;
          go(PH_RX_REL);
        end
      end
      PH_RX_REL: begin
        drv[0] = 1'b0;
        go(PH_RX_WAIT);
      end
      PH_RX_WAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_RX_HIGH);
        else if (r < 0) fail_stop();
      end
      PH_RX_HIGH: begin
        shb = {shb[6:0], sda};
        bidx = bidx + 4'd1;
        drv[0] = 1'b1;
        go(bidx >= 4'd8 ? PH_RX_ACKSET : PH_RX_REL);
      end
      PH_RX_ACKSET: begin
        drv[1] = left > 12'd1;
        go(PH_RX_ACKREL);
      end
      PH_RX_ACKREL: begin
        drv[0] = 1'b0;
        go(PH_RX_ACKWAIT);
      end
      PH_RX_ACKWAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_RX_ACKHIGH);
        else if (r < 0) fail_stop();
      end
      PH_RX_ACKHIGH: begin
        drv = 2'b01;
        o_valid = 1'b1;
        o_data = shb;
        left = left - 12'd1;
        if (left == 12'd0) begin
          tok = 1'b1;
          go(PH_SP_BEGIN);
        end else begin
          bidx = '0;
          shb = '0;
          go(PH_RX_REL);
        end
      end
      PH_SP_BEGIN: begin
        drv[1] = 1'b1;
        go(PH_SP_LOW);
      end
      PH_SP_LOW: begin
        drv[0] = 1'b0;
        go(PH_SP_WAIT);
      end
      PH_SP_WAIT: begin
        r = scl_wait(scl);
        if (r == 1) go(PH_SP_HIGH);
        else if (r < 0) begin
          drv[1] = 1'b0;
          go(PH_SP_END);
        end
      end
      PH_SP_HIGH: begin
        drv[1] = 1'b0;
        go(PH_SP_END);
      end
      PH_SP_END: begin
        if (kind == i2crm_pkg::KIND_RECOVER || stg >= i2crm_pkg::STG_REC) go(PH_CHECK);
        else end_xfer();
      end
      default: ;
    endcase
  endfunction

  // predict the result beat of one command and queue both
  function automatic void push_cmd(logic [2:0] op, logic scl, logic sda, logic [6:0] dev,
                                   logic [7:0] rg, logic [11:0] cnt, logic [7:0] wb);
    o_valid = 1'b0;
    o_data = '0;
    o_done = 1'b0;
    o_ok = 1'b0;
    if (op == i2crm_pkg::OP_TICK) bus_tick(scl, sda);
    else if ((op == i2crm_pkg::OP_WRITE || op == i2crm_pkg::OP_READ ||
              op == i2crm_pkg::OP_PROBE) && ph == PH_IDLE) begin
      haddr = dev;
      hreg = rg;
      left = (op == i2crm_pkg::OP_PROBE) ? 12'd0 : cnt;
      kind = op[1:0] - 2'd1;
      stg = i2crm_pkg::STG_ADDR_W;
      tok = 1'b0;
      bidx = '0;
      shb = '0;
      if (op == i2crm_pkg::OP_READ && cnt == 12'd0) finish_xfer(1'b0);
      else go(PH_CHECK);
    end else if (op == i2crm_pkg::OP_RECOVER && ph == PH_IDLE) begin
      kind = i2crm_pkg::KIND_RECOVER;
      tok = 1'b0;
      begin_recovery(i2crm_pkg::STG_REC);
    end else if (op == i2crm_pkg::OP_SUPPLY && ph == PH_NEED) begin
      stg = i2crm_pkg::STG_DATA;
      load_byte(wb);
    end
    cmd_q.push_back({wb, cnt, rg, dev, sda, scl, op});
    beat_q.push_back({1'b0, o_ok, o_done, ph != PH_IDLE, ph == PH_NEED, o_valid, o_data,
                      drv[1], drv[0]});
  endfunction

  // next command: a cooperative slave most of the time, with noise
  function automatic void gen_cmd(bit drain);
    logic [2:0]  op;
    logic        scl, sda;
    logic [11:0] cnt;
    int          r;
    r = $urandom_range(0, 99);
    if (drain) op = (ph == PH_NEED) ? i2crm_pkg::OP_SUPPLY : i2crm_pkg::OP_TICK;
    else if (ph == PH_IDLE) begin
      if (r < 30) op = i2crm_pkg::OP_WRITE;
      else if (r < 55) op = i2crm_pkg::OP_READ;
      else if (r < 70) op = i2crm_pkg::OP_PROBE;
      else if (r < 82) op = i2crm_pkg::OP_RECOVER;
      else if (r < 88) op = i2crm_pkg::OP_TICK;
      else if (r < 92) op = i2crm_pkg::OP_SUPPLY;
      else op = 3'($urandom_range(6, 7));
    end else if (ph == PH_NEED) begin
      op = (r < 80) ? i2crm_pkg::OP_SUPPLY : (r < 90) ? i2crm_pkg::OP_TICK
                                                      : 3'($urandom_range(0, 7));
    end else op = (r < 93) ? i2crm_pkg::OP_TICK : 3'($urandom_range(1, 7));
    scl = drain ? 1'b1 : ($urandom_range(0, 99) < 92);
    r = $urandom_range(0, 99);
    // while draining, ack only short transfers under a long ack timeout
    if (drain) sda = (ph == PH_ACK_HIGH) ? ((ack_to <= 16'd1000) || (left > 12'd16)) : 1'b1;
    else case (ph)
      PH_ACK_HIGH: sda = (r < ack_miss_pct);
      PH_REC_TEST, PH_RX_HIGH: sda = r[0];
      PH_IDLE, PH_CHECK: sda = (r < 90);
      default: sda = (r < 85) ? 1'b1 : 1'($urandom_range(0, 1));
    endcase
    r = $urandom_range(0, 99);
    if (op == i2crm_pkg::OP_READ) cnt = 12'($urandom_range(0, 6));
    else if (r < 80) cnt = 12'($urandom_range(0, 3));
    else if (r < 95) cnt = 12'($urandom_range(1, 6));
    else cnt = 12'($urandom_range(0, 4095));
    push_cmd(op, scl, sda, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), cnt,
             8'($urandom_range(0, 255)));
  endfunction

  // run the engine back to idle with released lines
  function automatic void drain_engine();
    while (ph != PH_IDLE) gen_cmd(1'b1);
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (cmd_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cmd_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result monitor and sink backpressure
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (beat_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = beat_q.pop_front();
        check_field("scl_pull_low", want[0], m_axis_tdata[0]);
        check_field("sda_pull_low", want[1], m_axis_tdata[1]);
        check_field("read_data", want[9:2], m_axis_tdata[9:2]);
        check_field("read_valid", want[10], m_axis_tdata[10]);
        check_field("need_byte", want[11], m_axis_tdata[11]);
        check_field("busy_res", want[12], m_axis_tdata[12]);
        check_field("done_res", want[13], m_axis_tdata[13]);
        check_field("success", want[14], m_axis_tdata[14]);
        if (want[10]) reads_seen++;
        if (want[13]) dones_seen++;
      end
      results_seen++;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300 && cmd_q.size() > 20) begin
      // long hold while the sender still has plenty to offer
      hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      i2crm_pkg::REG_STRETCH: stretch_to = val;
      i2crm_pkg::REG_ACK: ack_to = val[15:0];
      default: pulse_lim = val[4:0];
    endcase
  endtask

  task automatic wait_empty();
    while (cmd_q.size() > 0 || beat_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  logic [19:0] set_stretch[5] = '{20'd120000, 20'd0, 20'd3, 20'd1048575, 20'd2};
  logic [15:0] set_ack[5]     = '{16'd250, 16'd0, 16'd4, 16'd65535, 16'd1};
  logic [4:0]  set_pulse[5]   = '{5'd18, 5'd0, 5'd31, 5'd5, 5'd1};

  initial begin
    ph = PH_IDLE;
    bidx = '0; shb = '0; left = '0; wcnt = '0; pcnt = '0;
    haddr = '0; hreg = '0; kind = i2crm_pkg::KIND_WRITE; tok = 1'b0; drv = '0;
    stg = i2crm_pkg::STG_ADDR_W;
    stretch_to = i2crm_pkg::StretchTimeoutReset;
    ack_to = i2crm_pkg::AckTimeoutReset;
    pulse_lim = i2crm_pkg::PulseLimitReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: zero-length read, unknown ops, stray supply, recovery, busy begin
    push_cmd(i2crm_pkg::OP_READ, 1'b1, 1'b1, 7'h7f, 8'hff, 12'd0, 8'h00);
    push_cmd(3'd6, 1'b0, 1'b0, 7'h00, 8'h00, 12'hfff, 8'hff);
    push_cmd(3'd7, 1'b1, 1'b1, 7'h7f, 8'hff, 12'h000, 8'h00);
    push_cmd(i2crm_pkg::OP_SUPPLY, 1'b1, 1'b1, 7'h00, 8'h00, 12'd0, 8'hff);
    push_cmd(i2crm_pkg::OP_RECOVER, 1'b1, 1'b1, 7'h00, 8'h00, 12'd0, 8'h00);
    push_cmd(i2crm_pkg::OP_WRITE, 1'b1, 1'b1, 7'h7f, 8'hff, 12'hfff, 8'h00);
    repeat (6) push_cmd(i2crm_pkg::OP_TICK, 1'b1, 1'b0, 7'h00, 8'h00, 12'd0, 8'h00);
    drain_engine();
    // probe that meets a stuck bus and recovers
    push_cmd(i2crm_pkg::OP_PROBE, 1'b1, 1'b1, 7'h00, 8'h00, 12'hfff, 8'h00);
    repeat (4) push_cmd(i2crm_pkg::OP_TICK, 1'b0, 1'b0, 7'h00, 8'h00, 12'd0, 8'h00);
    drain_engine();
    // one-byte write that runs into a missing ack
    push_cmd(i2crm_pkg::OP_WRITE, 1'b1, 1'b1, 7'h55, 8'haa, 12'd1, 8'h00);
    drain_engine();
    wait_empty();

    // random phases, each under its own register setting, with one of three idling modes
    for (int p = 0; p < 5; p++) begin
      write_reg(i2crm_pkg::REG_STRETCH, set_stretch[p]);
      write_reg(i2crm_pkg::REG_ACK, {4'd0, set_ack[p]});
      write_reg(i2crm_pkg::REG_PULSE, {15'd0, set_pulse[p]});
      ack_miss_pct = (set_ack[p] > 1000) ? 0 : 15;
      case (p % 3)
        0: begin src_idle_pct = 15; snk_idle_pct = 79; end
        1: begin src_idle_pct = 79; snk_idle_pct = 15; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      repeat (150) gen_cmd(1'b0);
      drain_engine();
      wait_empty();
    end

    wait_empty();
    repeat (20) @(posedge clk);
    $display("checked %0d result beats over 5 register settings and a directed set",
             results_seen);
    $display("%0d transfers completed, %0d bytes read back", dones_seen, reads_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ i2c_register_master_core.f @@
rtl/core/i2crm_pkg.sv
rtl/core/i2crm_front.sv
rtl/core/i2crm_engine.sv
rtl/core/i2c_register_master_core.sv
test/tb_i2c_register_master_core.sv
